[hdl/socket_id_free_list_allocator_core_assert.svh]
// assertion macros shared by the socket id allocator modules
// depends on nothing; included by the controller and the datapath
`ifndef SOCKET_ID_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SOCKET_ID_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define SIDFL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sidfl check failed");

// same-cycle implication
`define SIDFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sidfl check failed");

// next-cycle implication
`define SIDFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sidfl check failed");

`endif

[hdl/sidfl_pkg.sv]
// shared types and codes of the socket id allocator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sidfl_pkg;

   // field widths fixed by the interface
   localparam int CSR_W = 11;
   localparam int OP_W  = 2;
   localparam int STS_W = 2;

   // pool size after reset, before clamping to the memory depth
   localparam int CSR_RESET = 1024;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // response status codes
   localparam logic [STS_W-1:0] STS_OK           = 2'd0;
   localparam logic [STS_W-1:0] STS_NO_FREE      = 2'd1;
   localparam logic [STS_W-1:0] STS_ALREADY_FREE = 2'd2;
   localparam logic [STS_W-1:0] STS_OUT_OF_RANGE = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic rebuild;
      logic clr_en;
      logic load;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
   } status_type;

endpackage

`default_nettype wire

[hdl/sidfl_ctrl.sv]
// controller of the socket id allocator: clearing pass, accept, execute
// depends on sidfl_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "socket_id_free_list_allocator_core_assert.svh"

module sidfl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire sidfl_pkg::status_type status,
   output sidfl_pkg::cmd_type        cmd
);

   sidfl_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_valid) begin
         state_in = sidfl_pkg::ST_CLEAR;
      end else begin
         unique case (state_ff)
            sidfl_pkg::ST_CLEAR: begin
               if (status.clr_last) begin
                  state_in = sidfl_pkg::ST_IDLE;
               end
            end
            sidfl_pkg::ST_IDLE: begin
               if (req_valid) begin
                  state_in = sidfl_pkg::ST_EXEC;
               end
            end
            sidfl_pkg::ST_EXEC: begin
               if (rsp_free) begin
                  state_in = sidfl_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = sidfl_pkg::ST_CLEAR;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      req_stall   = (state_ff != sidfl_pkg::ST_IDLE);
      csr_ready   = 1'b1;
      cmd.rebuild = csr_valid;
      cmd.clr_en  = (state_ff == sidfl_pkg::ST_CLEAR);
      cmd.load    = (state_ff == sidfl_pkg::ST_IDLE) && req_valid;
      cmd.exec    = (state_ff == sidfl_pkg::ST_EXEC) && rsp_free;
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sidfl_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SIDFL_ASSERT_NEXT(a_load_to_exec, clock, reset, cmd.load && !csr_valid,
      state_ff == sidfl_pkg::ST_EXEC)
   `SIDFL_ASSERT_IMPLY(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff), $past(cmd.exec))
   `SIDFL_ASSERT_NEXT(a_clear_ends, clock, reset,
      cmd.clr_en && status.clr_last && !csr_valid, state_ff == sidfl_pkg::ST_IDLE)

endmodule

`default_nettype wire

[hdl/sidfl_datapath.sv]
// datapath of the socket id allocator: free ring, type table, pointers, response
// depends on sidfl_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "socket_id_free_list_allocator_core_assert.svh"

module sidfl_datapath #(
   parameter int MAX_SOCKETS = 1024,
   parameter int TYPE_BITS   = 4,
   parameter int ID_W        = 10,
   parameter int CNT_W       = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sidfl_pkg::cmd_type          cmd,
   output sidfl_pkg::status_type            status,
   input  wire logic [sidfl_pkg::CSR_W-1:0] csr_data,
   input  wire logic [sidfl_pkg::OP_W-1:0]  req_opcode,
   input  wire logic [TYPE_BITS-1:0]        req_sock_type,
   input  wire logic [ID_W-1:0]             req_sock_id,
   output logic [sidfl_pkg::STS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]                  rsp_result_id,
   output logic [TYPE_BITS-1:0]             rsp_result_type
);

   localparam int RST_ACTIVE = (MAX_SOCKETS < sidfl_pkg::CSR_RESET) ?
                               MAX_SOCKETS : sidfl_pkg::CSR_RESET;
   localparam int RST_TAIL   = RST_ACTIVE % MAX_SOCKETS;

   localparam logic [ID_W-1:0]  LAST_ID = ID_W'(MAX_SOCKETS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SOCKETS);

   logic [ID_W-1:0]      ring_mem [MAX_SOCKETS];
   logic [TYPE_BITS-1:0] type_mem [MAX_SOCKETS];

   logic [CNT_W-1:0] active_ff;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [ID_W-1:0]  head_ff, head_in;
   logic [ID_W-1:0]  tail_ff, tail_in;
   logic [ID_W-1:0]  clr_idx_ff;

   logic [sidfl_pkg::OP_W-1:0] op_ff;
   logic [TYPE_BITS-1:0]       tag_ff;
   logic [ID_W-1:0]            id_ff;
   logic [ID_W-1:0]            ring_rd_ff;
   logic [TYPE_BITS-1:0]       type_rd_ff;

   logic [sidfl_pkg::STS_W-1:0] sts_ff, sts_in;
   logic [ID_W-1:0]             rid_ff, rid_in;
   logic [TYPE_BITS-1:0]        rtype_ff, rtype_in;

   logic                 ring_we;
   logic [ID_W-1:0]      ring_waddr, ring_wdata;
   logic                 type_we;
   logic [ID_W-1:0]      type_waddr;
   logic [TYPE_BITS-1:0] type_wdata;

   logic [31:0]      csr_wide;
   logic [CNT_W-1:0] new_active;
   logic [ID_W-1:0]  new_tail;
   logic             id_in_range;

   // clamp the written pool size into 1 .. MAX_SOCKETS
   always_comb begin
      csr_wide = 32'(csr_data);
      if (csr_wide == 32'd0) begin
         new_active = CNT_W'(1);
      end else if (csr_wide > 32'(MAX_SOCKETS)) begin
         new_active = MAX_CNT;
      end else begin
         new_active = CNT_W'(csr_wide);
      end
      new_tail = (new_active == MAX_CNT) ? '0 : new_active[ID_W-1:0];
   end

   assign status.clr_last = (clr_idx_ff == LAST_ID);
   assign id_in_range     = (CNT_W'(id_ff) < active_ff);

   // operation execute
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_cnt_in = free_cnt_ff;
      sts_in      = sidfl_pkg::STS_OK;
      rid_in      = id_ff;
      rtype_in    = '0;
      ring_we     = 1'b0;
      ring_waddr  = clr_idx_ff;
      ring_wdata  = clr_idx_ff;
      type_we     = 1'b0;
      type_waddr  = clr_idx_ff;
      type_wdata  = '0;

      unique case (op_ff)
         sidfl_pkg::OP_ALLOC: begin
            if (free_cnt_ff == '0) begin
               sts_in = sidfl_pkg::STS_NO_FREE;
               rid_in = '0;
            end else begin
               rid_in      = ring_rd_ff;
               rtype_in    = tag_ff;
               head_in     = (head_ff == LAST_ID) ? '0 : head_ff + ID_W'(1);
               free_cnt_in = free_cnt_ff - CNT_W'(1);
               type_we     = cmd.exec;
               type_waddr  = ring_rd_ff;
               type_wdata  = tag_ff;
            end
         end
         sidfl_pkg::OP_FREE: begin
            if (!id_in_range) begin
               sts_in = sidfl_pkg::STS_OUT_OF_RANGE;
            end else if (type_rd_ff == '0) begin
               sts_in = sidfl_pkg::STS_ALREADY_FREE;
            end else begin
               type_we    = cmd.exec;
               type_waddr = id_ff;
               type_wdata = '0;
               // ring cannot overflow here, kept as a guard
               if (free_cnt_ff < MAX_CNT) begin
                  ring_we     = cmd.exec;
                  ring_waddr  = tail_ff;
                  ring_wdata  = id_ff;
                  tail_in     = (tail_ff == LAST_ID) ? '0 : tail_ff + ID_W'(1);
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end
         end
         sidfl_pkg::OP_LOOKUP: begin
            if (!id_in_range) begin
               sts_in = sidfl_pkg::STS_OUT_OF_RANGE;
            end else begin
               rtype_in = type_rd_ff;
            end
         end
         default: begin
            sts_in = sidfl_pkg::STS_OUT_OF_RANGE;
         end
      endcase

      // clearing pass: one entry of each memory per cycle
      if (cmd.clr_en) begin
         ring_we    = 1'b1;
         ring_waddr = clr_idx_ff;
         ring_wdata = clr_idx_ff;
         type_we    = 1'b1;
         type_waddr = clr_idx_ff;
         type_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= CNT_W'(RST_ACTIVE);
         free_cnt_ff <= CNT_W'(RST_ACTIVE);
         head_ff     <= '0;
         tail_ff     <= ID_W'(RST_TAIL);
         clr_idx_ff  <= '0;
      end else if (cmd.rebuild) begin
         active_ff   <= new_active;
         free_cnt_ff <= new_active;
         head_ff     <= '0;
         tail_ff     <= new_tail;
         clr_idx_ff  <= '0;
      end else begin
         if (cmd.clr_en) begin
            clr_idx_ff <= status.clr_last ? '0 : clr_idx_ff + ID_W'(1);
         end
         if (cmd.exec) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            free_cnt_ff <= free_cnt_in;
         end
      end
   end

   // request capture and registered memory reads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         tag_ff     <= req_sock_type;
         id_ff      <= req_sock_id;
         ring_rd_ff <= ring_mem[head_ff];
         type_rd_ff <= type_mem[req_sock_id];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (type_we) begin
         type_mem[type_waddr] <= type_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sts_ff   <= sts_in;
         rid_ff   <= rid_in;
         rtype_ff <= rtype_in;
      end
   end

   assign rsp_status      = sts_ff;
   assign rsp_result_id   = rid_ff;
   assign rsp_result_type = rtype_ff;

   `SIDFL_ASSERT_ALWAYS(a_count_in_pool, clock, reset, free_cnt_ff <= active_ff)
   `SIDFL_ASSERT_NEXT(a_empty_alloc_holds, clock, reset,
      cmd.exec && !cmd.rebuild && op_ff == sidfl_pkg::OP_ALLOC && free_cnt_ff == '0,
      $stable(head_ff) && $stable(free_cnt_ff))
   `SIDFL_ASSERT_NEXT(a_rebuild_restarts, clock, reset, cmd.rebuild,
      clr_idx_ff == '0 && head_ff == '0 && free_cnt_ff == active_ff)

endmodule

`default_nettype wire

[hdl/socket_id_free_list_allocator_core.sv]
// top level of the socket id allocator: controller plus datapath
// depends on sidfl_pkg, sidfl_ctrl and sidfl_datapath
`timescale 1ns / 1ps
`default_nettype none

// Socket id allocator with a first-in first-out free list. Free ids wait in a
// ring memory and every id carries a type tag in a second memory (tag zero
// means unused). Opcode allocate pops the ring head and tags that id, free
// clears the tag and pushes the id at the ring tail, lookup returns the tag.
// Each request passes the transfer, which also issues the registered reads
// of both memories, and the execute state, which waits while a stalled
// response fills the response register and then writes the memories and
// loads that register; one request is in flight at a time, and the next
// request is taken while the previous response still waits in its register.
// After reset and after every csr transfer a clearing pass rewrites both
// memories one entry per cycle; req_stall is high during that pass. csr_ready
// is always high; csr_data is clamped into 1 .. MAX_SOCKETS and rebuilds the
// pool, so write it only while the block has no request in flight.

module socket_id_free_list_allocator_core #(
   parameter int MAX_SOCKETS = 1024,
   parameter int TYPE_BITS   = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [sidfl_pkg::OP_W-1:0]          req_opcode,
   input  wire logic [TYPE_BITS-1:0]                req_sock_type,
   input  wire logic [$clog2(MAX_SOCKETS)-1:0]      req_sock_id,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [sidfl_pkg::STS_W-1:0]              rsp_status,
   output logic [$clog2(MAX_SOCKETS)-1:0]           rsp_result_id,
   output logic [TYPE_BITS-1:0]                     rsp_result_type,
   // pool size register
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sidfl_pkg::CSR_W-1:0]         csr_data
);

   // id width covers the ring depth, count width also holds the depth itself
   localparam int ID_W  = $clog2(MAX_SOCKETS);
   localparam int CNT_W = $clog2(MAX_SOCKETS + 1);

   sidfl_pkg::cmd_type    cmd;
   sidfl_pkg::status_type status;

   // state machine: clearing pass, idle, execute
   sidfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, ring pointers, free count and response register
   sidfl_datapath #(
      .MAX_SOCKETS (MAX_SOCKETS),
      .TYPE_BITS   (TYPE_BITS),
      .ID_W        (ID_W),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_data        (csr_data),
      .req_opcode      (req_opcode),
      .req_sock_type   (req_sock_type),
      .req_sock_id     (req_sock_id),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_result_type (rsp_result_type)
   );

endmodule

`default_nettype wire
